// File: rtl/core/baro_sensor_compensation_macros.svh
// ============================================================================
// Barometric sensor compensation assertion macros
// Shared concurrent assertion forms for the compensation RTL.
// ============================================================================
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compensation check failed in the same cycle");

// Antecedent implies consequent in the next cycle.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compensation check failed one cycle later");

`endif

// File: rtl/core/bsc_pkg.sv
// ============================================================================
// Barometric sensor compensation package
// Beat types, register indexes, command codes and the output clamp.
// ============================================================================
package bsc_pkg;

    localparam int unsigned CoeffWidth = 16;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned StateWidth = 48;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] REG_SENS_BASE  = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_OFF_BASE   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SENS_TEMP  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_OFF_TEMP   = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_REF_TEMP   = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_TEMP_SLOPE = 3'd5;

    // Command and result kind codes.
    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // Stale counter values.
    localparam logic [1:0] STALE_CLEAR = 2'd0;
    localparam logic [1:0] STALE_ONCE  = 2'd1;
    localparam logic [1:0] STALE_MAX   = 2'd3;

    // Temperature offset in hundredths of a degree.
    localparam logic signed [58:0] TEMP_BASE = 59'sd2000;

    typedef struct packed {
        logic        command;
        logic [15:0] raw_low;
        logic [15:0] raw_high;
    } bsc_item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] value;
        logic               stale_warning;
    } bsc_result_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [58:0] v);
        logic signed [31:0] r;
        if (v > 59'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -59'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/baro_sensor_compensation.sv
// ============================================================================
// Barometric sensor first-order compensation
// Path: a beat goes through the stage 0, 1 and 2 registers into the result register.
// Throughput: one beat per cycle unless result_stall holds it, in the four-stage pipeline with per-stage stalls.
// Reset: rst_n clears valids and coefficients, zeros the terms, sets stale count to one.
// ============================================================================
`include "baro_sensor_compensation_macros.svh"

module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration write port.
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CoeffWidth-1:0]    cfg_data,
    // Raw conversion beats.
    input  logic                     item_valid,
    output logic                     item_stall,
    input  bsc_item_t                item,
    // Compensated result beats.
    output logic                     result_valid,
    input  logic                     result_stall,
    output bsc_result_t              result
);

    // ------------------------------------------------------------------------
    // Calibration coefficients.
    // ------------------------------------------------------------------------
    logic [CoeffWidth-1:0] sens_base_reg;
    logic [CoeffWidth-1:0] off_base_reg;
    logic [CoeffWidth-1:0] sens_temp_reg;
    logic [CoeffWidth-1:0] off_temp_reg;
    logic [CoeffWidth-1:0] ref_temp_reg;
    logic [CoeffWidth-1:0] temp_slope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_base_reg  <= '0;
            off_base_reg   <= '0;
            sens_temp_reg  <= '0;
            off_temp_reg   <= '0;
            ref_temp_reg   <= '0;
            temp_slope_reg <= '0;
        end
        else if (cfg_write)
        begin
            // Indexes past the last register are dropped.
            unique case (cfg_index)
                REG_SENS_BASE:  sens_base_reg  <= cfg_data;
                REG_OFF_BASE:   off_base_reg   <= cfg_data;
                REG_SENS_TEMP:  sens_temp_reg  <= cfg_data;
                REG_OFF_TEMP:   off_temp_reg   <= cfg_data;
                REG_REF_TEMP:   ref_temp_reg   <= cfg_data;
                REG_TEMP_SLOPE: temp_slope_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control. Each stage moves when its successor has room, so
    // bubbles collapse and a waiting result does not block new beats until
    // every stage is occupied.
    // ------------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic en0, en1, en2, en3;

    assign en3 = !v3_reg || !result_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign item_stall   = !en0;
    assign result_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= item_valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: input register. The temperature difference dT is the raw word
    // minus the reference reading scaled by 256, wrapped to 32 bits; it is
    // formed on the way in so that stage 1 only has a multiply ahead of it.
    // ------------------------------------------------------------------------
    logic [31:0]        raw_in;
    logic signed [31:0] dt_next;
    logic               kind0_reg;
    logic [31:0]        raw0_reg;
    logic signed [31:0] dt0_reg;

    assign raw_in  = {item.raw_high, item.raw_low};
    assign dt_next = $signed(raw_in - {8'b0, ref_temp_reg, 8'b0});

    always_ff @(posedge clk)
    begin
        if (en0 && item_valid)
        begin
            kind0_reg <= item.command;
            raw0_reg  <= raw_in;
            dt0_reg   <= dt_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0 to 1. A temperature beat updates the offset and sensitivity
    // terms as it leaves stage 0; because beats leave in order, a pressure
    // beat right behind it already sees the new terms. Pressure splits the
    // 48-bit factor of the 32 by 48 bit product into low 16 and high 32 bits.
    // ------------------------------------------------------------------------
    logic signed [StateWidth-1:0] offset_term_reg;
    logic signed [StateWidth-1:0] sensitivity_term_reg;
    logic [1:0]                   stale_count_reg;

    logic signed [48:0]            off_prod;
    logic signed [48:0]            sens_prod;
    logic signed [48:0]            slope_prod;
    logic signed [StateWidth-1:0]  offset_next;
    logic signed [StateWidth-1:0]  sensitivity_next;
    logic [47:0]                   press_lo;
    logic signed [64:0]            press_hi;
    logic                          stale_hit;
    logic                          move1;

    assign move1 = en1 && v0_reg;

    assign off_prod   = $signed({1'b0, off_temp_reg}) * dt0_reg;
    assign sens_prod  = $signed({1'b0, sens_temp_reg}) * dt0_reg;
    assign slope_prod = $signed({1'b0, temp_slope_reg}) * dt0_reg;

    assign offset_next      = $signed({15'b0, off_base_reg, 17'b0})
                            + StateWidth'(off_prod >>> 6);
    assign sensitivity_next = $signed({16'b0, sens_base_reg, 16'b0})
                            + StateWidth'(sens_prod >>> 7);

    assign press_lo = raw0_reg * sensitivity_term_reg[15:0];
    assign press_hi = $signed({1'b0, raw0_reg}) * $signed(sensitivity_term_reg[47:16]);

    // The warning marks the second pressure beat since the last temperature.
    assign stale_hit = (stale_count_reg == STALE_ONCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_term_reg      <= '0;
            sensitivity_term_reg <= '0;
            stale_count_reg      <= STALE_ONCE;
        end
        else if (move1)
        begin
            if (kind0_reg == CMD_TEMP)
            begin
                offset_term_reg      <= offset_next;
                sensitivity_term_reg <= sensitivity_next;
                stale_count_reg      <= STALE_CLEAR;
            end
            else if (stale_count_reg != STALE_MAX)
            begin
                stale_count_reg <= stale_count_reg + 2'd1;
            end
        end
    end

    logic                          kind1_reg;
    logic                          warn1_reg;
    logic [47:0]                   lo1_reg;
    logic signed [63:0]            hi1_reg;
    logic signed [StateWidth-1:0]  off1_reg;

    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            kind1_reg <= kind0_reg;
            if (kind0_reg == CMD_TEMP)
            begin
                warn1_reg <= 1'b0;
                lo1_reg   <= '0;
                hi1_reg   <= 64'(slope_prod);
                off1_reg  <= '0;
            end
            else
            begin
                warn1_reg <= stale_hit;
                lo1_reg   <= press_lo;
                hi1_reg   <= press_hi[63:0];
                // The offset travels with the beat, since a later temperature
                // beat may overwrite the stored term.
                off1_reg  <= offset_term_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 to 2. Pressure joins the partial products and takes
    // floor(product / 2^21) as the upper bits. Temperature forms
    // 2000 + floor(dT * slope / 2^23).
    // ------------------------------------------------------------------------
    logic signed [79:0] full_prod;
    logic signed [58:0] sum_next;
    logic               kind2_reg;
    logic               warn2_reg;
    logic signed [58:0] sum2_reg;
    logic signed [StateWidth-1:0] off2_reg;

    assign full_prod = $signed({hi1_reg, 16'b0}) + $signed({32'b0, lo1_reg});
    assign sum_next  = (kind1_reg == CMD_TEMP) ? 59'(hi1_reg >>> 23) + TEMP_BASE
                                               : full_prod[79:21];

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            kind2_reg <= kind1_reg;
            warn2_reg <= warn1_reg;
            sum2_reg  <= sum_next;
            off2_reg  <= off1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2 to 3. Pressure subtracts the offset and divides by 2^15 with
    // floor; the quotient keeps its sign as it is widened. Both kinds are
    // clamped to 32 bits into the result register.
    // ------------------------------------------------------------------------
    logic signed [59:0] press_diff;
    logic signed [58:0] wide_value;

    assign press_diff = 60'(sum2_reg) - 60'(off2_reg);
    assign wide_value = (kind2_reg == CMD_TEMP) ? sum2_reg
                                                : 59'($signed(press_diff[59:15]));

    bsc_result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            result_reg.result_kind   <= kind2_reg;
            result_reg.value         <= sat32(wide_value);
            result_reg.stale_warning <= warn2_reg;
        end
    end

    assign result = result_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `BSC_ASSERT_SAME(a_temp_no_warning, clk, rst_n,
        result_valid && (result.result_kind == CMD_TEMP), !result.stale_warning)
    `BSC_ASSERT_NEXT(a_temp_clears_stale, clk, rst_n,
        move1 && (kind0_reg == CMD_TEMP), stale_count_reg == STALE_CLEAR)
    `BSC_ASSERT_SAME(a_empty_input_takes, clk, rst_n, !v0_reg, !item_stall)
    `BSC_ASSERT_NEXT(a_blocked_out_holds, clk, rst_n,
        v3_reg && result_stall && v2_reg, v3_reg && v2_reg)

endmodule
